// File: rtl/frame_autocorrelation_macros.svh
// -----------------------------------------------------------------------------
// Frame autocorrelation assertion macros
// Shared property wrappers for the clocked checks in the RTL.
// -----------------------------------------------------------------------------
`ifndef FRAME_AUTOCORRELATION_MACROS_SVH
`define FRAME_AUTOCORRELATION_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define FAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/fac_pkg.sv
// -----------------------------------------------------------------------------
// fac_pkg
// Shared widths, register codes and control types of the frame autocorrelator.
// -----------------------------------------------------------------------------
package fac_pkg;

  localparam int ORDER_MAX_DEF = 32;
  localparam int FRAME_MAX_DEF = 4096;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 32;
  localparam int VALUE_W    = 48;
  localparam int LAG_W      = 6;
  localparam int FLEN_W     = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 56;

  localparam logic [FLEN_W-1:0] FLEN_RESET  = 13'd256;
  localparam logic [LAG_W-1:0]  ORDER_RESET = 6'd16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAG_ORDER = 1'b1;

  // Per-cycle commands broadcast along the cell chain
  typedef struct packed {
    logic step;   // a sample transfer is accepted this cycle
    logic snap;   // this sample closes the frame: capture sums, clear state
    logic shift;  // a result transfer completes: advance the result chain
  } cell_ctl_t;

endpackage

// File: rtl/fac_cell.sv
// -----------------------------------------------------------------------------
// fac_cell
// One lag of the autocorrelator: delay tap, multiply-accumulate, result stage.
// -----------------------------------------------------------------------------
module fac_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fac_pkg::cell_ctl_t                  ctl_i,
  input  logic signed [fac_pkg::SAMPLE_W-1:0] x_i,
  input  logic signed [fac_pkg::SAMPLE_W-1:0] prev_i,
  input  logic signed [fac_pkg::VALUE_W-1:0]  hold_i,
  output logic signed [fac_pkg::SAMPLE_W-1:0] tap_o,
  output logic signed [fac_pkg::VALUE_W-1:0]  hold_o
);
  import fac_pkg::*;

  logic signed [SAMPLE_W-1:0] tap_r,  tap_nxt;
  logic signed [VALUE_W-1:0]  acc_r,  acc_nxt;
  logic signed [VALUE_W-1:0]  hold_r, hold_nxt;
  logic signed [PROD_W-1:0]   prod;
  logic signed [VALUE_W-1:0]  acc_sum;

  assign prod    = x_i * prev_i;
  assign acc_sum = acc_r + VALUE_W'(prod);

  always_comb begin
    tap_nxt  = tap_r;
    acc_nxt  = acc_r;
    hold_nxt = hold_r;
    if (ctl_i.step) begin
      tap_nxt = ctl_i.snap ? '0 : prev_i;
      acc_nxt = ctl_i.snap ? '0 : acc_sum;
    end
    // capture wins over advance: the chain is empty or draining its last entry
    if (ctl_i.snap) begin
      hold_nxt = acc_sum;
    end else if (ctl_i.shift) begin
      hold_nxt = hold_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r <= '0;
      acc_r <= '0;
    end else begin
      tap_r <= tap_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  assign tap_o  = tap_r;
  assign hold_o = hold_r;

endmodule

// File: rtl/fac_ctrl.sv
// -----------------------------------------------------------------------------
// fac_ctrl
// Frame counter, input flow control and result sequencer.
// -----------------------------------------------------------------------------
`include "frame_autocorrelation_macros.svh"

module fac_ctrl #(
  parameter int ORDER_MAX = fac_pkg::ORDER_MAX_DEF,
  parameter int FRAME_MAX = fac_pkg::FRAME_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [fac_pkg::FLEN_W-1:0]       frame_len_i,
  input  logic [fac_pkg::LAG_W-1:0]        lag_order_i,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic                             out_tready,
  output logic                             out_tvalid,
  output logic [fac_pkg::LAG_W-1:0]        lag_index_o,
  output logic                             last_o,
  output logic                             err_o,
  output fac_pkg::cell_ctl_t               ctl_o
);
  import fac_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX + 1);
  localparam int CMP_W = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;
  localparam int PW    = $clog2(ORDER_MAX + 2);

  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [PW-1:0]    pend_r, pend_nxt;
  logic [LAG_W-1:0] idx_r,  idx_nxt;
  logic             err_r,  err_nxt;

  logic [CMP_W-1:0] flen_ext;
  logic [CMP_W-1:0] len_eff;
  logic [CMP_W-1:0] seen_inc;
  logic [LAG_W-1:0] order_eff;
  logic             ends;
  logic             step;
  logic             out_fire;

  // effective frame length: zero counts as one, clamp to the frame limit
  always_comb begin
    flen_ext = CMP_W'(frame_len_i);
    if (flen_ext == '0) begin
      len_eff = CMP_W'(1);
    end else if (flen_ext > CMP_W'(FRAME_MAX)) begin
      len_eff = CMP_W'(FRAME_MAX);
    end else begin
      len_eff = flen_ext;
    end
  end

  assign order_eff = (lag_order_i > LAG_W'(ORDER_MAX)) ? LAG_W'(ORDER_MAX) : lag_order_i;
  assign seen_inc  = CMP_W'(seen_r) + CMP_W'(1);
  assign ends      = (seen_inc >= len_eff);

  assign out_tvalid = (pend_r != '0);
  assign out_fire   = out_tvalid && out_tready;

  // hold a frame-closing sample until the result chain is free
  assign in_tready = !ends || (pend_r == '0) || (out_tready && (pend_r == PW'(1)));
  assign step      = in_tvalid && in_tready;

  assign ctl_o.step  = step;
  assign ctl_o.snap  = step && ends;
  assign ctl_o.shift = out_fire;

  always_comb begin
    seen_nxt = seen_r;
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    err_nxt  = err_r;
    if (step) begin
      seen_nxt = ends ? '0 : CNT_W'(seen_inc);
    end
    if (step && ends) begin
      err_nxt  = (len_eff <= CMP_W'(order_eff));
      pend_nxt = err_nxt ? PW'(1) : PW'(order_eff) + PW'(1);
      idx_nxt  = '0;
    end else if (out_fire) begin
      pend_nxt = pend_r - PW'(1);
      idx_nxt  = idx_r + LAG_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      pend_r <= '0;
      idx_r  <= '0;
      err_r  <= 1'b0;
    end else begin
      seen_r <= seen_nxt;
      pend_r <= pend_nxt;
      idx_r  <= idx_nxt;
      err_r  <= err_nxt;
    end
  end

  assign lag_index_o = idx_r;
  assign last_o      = (pend_r == PW'(1));
  assign err_o       = err_r;

  `FAC_ASSERT(a_snap_needs_room, ctl_o.snap |-> ((pend_r == '0) || (out_fire && last_o)), "frame closed while results still queued")
  `FAC_ASSERT(a_snap_restarts, ctl_o.snap |=> ((idx_r == '0) && (pend_r != '0)), "result sequence not restarted after frame end")
  `FAC_ASSERT(a_drain_empties, (out_fire && last_o && !ctl_o.snap) |=> (pend_r == '0), "results left after final transfer")
  `FAC_ASSERT(a_error_single, (err_r && out_tvalid) |-> ((pend_r == PW'(1)) && (idx_r == '0)), "error frame gives more than one result")
  `FAC_ASSERT_ALWAYS(a_reset_idle, (!rst_n) |=> !out_tvalid, "results pending after reset")

endmodule

// File: rtl/frame_autocorrelation.sv
// Results: lag 0 of a frame is offered in the cycle after the transfer of the frame's last sample;
//   lags 1..order follow one per cycle while out_tready stays high.
// Throughput: one sample per cycle, set by the single multiply-accumulate in each lag cell.
//   A frame-closing sample waits only while the previous frame's results have not drained.
// Reset (synchronous, rst_n low): delay line, accumulators and counters cleared,
//   frame length back to 256 and lag_order to 16.
// -----------------------------------------------------------------------------
// frame_autocorrelation
// Short-time autocorrelation over fixed-length frames, built as a chain of
// lag cells that share the incoming sample and pass the delayed one along.
// -----------------------------------------------------------------------------
module frame_autocorrelation #(
  parameter int ORDER_MAX = fac_pkg::ORDER_MAX_DEF,
  parameter int FRAME_MAX = fac_pkg::FRAME_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [fac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fac_pkg::FLEN_W-1:0]        cfg_wdata,
  // sample stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fac_pkg::IN_DATA_W-1:0]     in_tdata,   // [15:0] sample
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fac_pkg::OUT_DATA_W-1:0]    out_tdata,  // [5:0] lag_index, [53:6] value, zero pad
  output logic                              out_tlast,
  output logic                              out_tuser   // [0] config_error
);
  import fac_pkg::*;

  logic [FLEN_W-1:0] frame_len_r, frame_len_nxt;
  logic [LAG_W-1:0]  lag_order_r, lag_order_nxt;

  cell_ctl_t                  ctl;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [SAMPLE_W-1:0] prev_w [0:ORDER_MAX];
  logic signed [VALUE_W-1:0]  hold_w [0:ORDER_MAX+1];
  logic [LAG_W-1:0]           lag_index;
  logic                       err;
  logic signed [VALUE_W-1:0]  value;

  // Configuration registers: take a write whenever the enable is high.
  always_comb begin
    frame_len_nxt = frame_len_r;
    lag_order_nxt = lag_order_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LEN: frame_len_nxt = cfg_wdata;
        REG_LAG_ORDER: lag_order_nxt = cfg_wdata[LAG_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FLEN_RESET;
      lag_order_r <= ORDER_RESET;
    end else begin
      frame_len_r <= frame_len_nxt;
      lag_order_r <= lag_order_nxt;
    end
  end

  fac_ctrl #(
    .ORDER_MAX (ORDER_MAX),
    .FRAME_MAX (FRAME_MAX)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_len_i (frame_len_r),
    .lag_order_i (lag_order_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .lag_index_o (lag_index),
    .last_o      (out_tlast),
    .err_o       (err),
    .ctl_o       (ctl)
  );

  assign x = in_tdata[SAMPLE_W-1:0];

  // Lag 0 multiplies the sample by itself; lag m by the tap of cell m-1.
  assign prev_w[0]             = x;
  assign hold_w[ORDER_MAX + 1] = '0;

  for (genvar m = 0; m <= ORDER_MAX; m++) begin : g_cell
    if (m < ORDER_MAX) begin : g_mid
      fac_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_i  (ctl),
        .x_i    (x),
        .prev_i (prev_w[m]),
        .hold_i (hold_w[m + 1]),
        .tap_o  (prev_w[m + 1]),
        .hold_o (hold_w[m])
      );
    end else begin : g_end
      // the deepest tap feeds nothing
      fac_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl_i  (ctl),
        .x_i    (x),
        .prev_i (prev_w[m]),
        .hold_i (hold_w[m + 1]),
        .tap_o  (),
        .hold_o (hold_w[m])
      );
    end
  end

  // Drop the captured sum on an error result: its value is zero.
  assign value     = err ? '0 : hold_w[0];
  assign out_tdata = {(OUT_DATA_W - VALUE_W - LAG_W)'(0), value, lag_index};
  assign out_tuser = err;

endmodule

// File: sim/frame_autocorrelation_tb.sv
// -----------------------------------------------------------------------------
// frame_autocorrelation_tb
// Self-checking testbench for the frame autocorrelator. A driver streams signed
// samples and a monitor predicts every lag sum of each closed frame. The
// monitor then checks the result stream field by field. Both handshakes idle at
// random, and the frame length and lag order change between phases, including
// part-way through a frame.
// -----------------------------------------------------------------------------
module frame_autocorrelation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fac_pkg::*;

  localparam int RESET_CYCLES   = 6;
  localparam int RANDOM_SAMPLES = 100;
  localparam int SETTLE_CYCLES  = 8;    // lag 0 is offered in the cycle after the closing sample
  localparam int MAX_REPORTS    = 20;

  // One autocorrelation result as the block presents it
  typedef struct packed {
    logic [LAG_W-1:0]   lag;
    logic [VALUE_W-1:0] acc_value;
    logic               last;
    logic               cfg_err;
  } lag_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [FLEN_W-1:0]     cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // [15:0] sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // [5:0] lag_index, [53:6] value, zero pad
  logic                  out_tlast;
  logic                  out_tuser;         // [0] config_error

  frame_autocorrelation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadows, delay line, lag accumulators, fill count
  // ---------------------------------------------------------------------------
  logic [FLEN_W-1:0]          frame_len_reg = FLEN_RESET;
  logic [LAG_W-1:0]           order_reg     = ORDER_RESET;
  logic signed [SAMPLE_W-1:0] history [ORDER_MAX_DEF]   = '{default: '0};
  logic [VALUE_W-1:0]         lag_acc [ORDER_MAX_DEF+1] = '{default: '0};
  int                         frame_fill    = 0;

  lag_result_t         lag_queue[$];       // lag sums still to come out, oldest first
  logic [SAMPLE_W-1:0] sample_backlog[$];  // samples waiting for the driver

  int send_idle_pct = 23;
  int recv_idle_pct = 45;
  int samples_queued = 0;
  int samples_taken  = 0;
  int results_seen   = 0;
  int frames_closed  = 0;
  int error_frames   = 0;
  int mismatches     = 0;
  bit sample_taken_flag = 1'b0;

  // Clock: 20 ns period
  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake hangs
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Frame length as the block sees it: zero acts as one, saturate at the maximum
  function automatic int eff_frame_len();
    if (frame_len_reg == '0)
      return 1;
    if (int'(frame_len_reg) > FRAME_MAX_DEF)
      return FRAME_MAX_DEF;
    return int'(frame_len_reg);
  endfunction

  // Lag order as the block sees it: saturate at the delay line length
  function automatic int eff_lag_order();
    if (int'(order_reg) > ORDER_MAX_DEF)
      return ORDER_MAX_DEF;
    return int'(order_reg);
  endfunction

  function automatic void clear_frame();
    foreach (history[i]) history[i] = '0;
    foreach (lag_acc[i]) lag_acc[i] = '0;
    frame_fill = 0;
  endfunction

  // Fold one sample into every lag accumulator; on the closing sample queue the
  // frame's lag sums (or the single error result) and start a fresh frame.
  function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] x);
    logic signed [SAMPLE_W-1:0] partner;
    logic signed [PROD_W-1:0]   prod;
    lag_result_t                res;
    int                         len;
    int                         order;
    // Every lag accumulates on every sample, whatever the current order
    for (int m = 0; m <= ORDER_MAX_DEF; m++) begin
      partner    = (m == 0) ? x : history[m-1];
      prod       = x * partner;
      lag_acc[m] = lag_acc[m] + {{(VALUE_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    for (int i = ORDER_MAX_DEF - 1; i > 0; i--)
      history[i] = history[i-1];
    history[0] = x;
    frame_fill++;

    // Registers may have moved mid-frame: close as soon as the fill reaches the length
    len   = eff_frame_len();
    order = eff_lag_order();
    if (frame_fill < len)
      return;

    frames_closed++;
    if (len <= order) begin
      // Frame too short for the order: one flagged result, value forced to zero
      res = '{lag: '0, acc_value: '0, last: 1'b1, cfg_err: 1'b1};
      lag_queue.push_back(res);
      error_frames++;
    end else begin
      for (int k = 0; k <= order; k++) begin
        res = '{lag: LAG_W'(k), acc_value: lag_acc[k], last: (k == order), cfg_err: 1'b0};
        lag_queue.push_back(res);
      end
    end
    clear_frame();
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Compare the result transfer on the bus with the oldest predicted lag
  task automatic check_result();
    lag_result_t want;
    if (lag_queue.size() == 0) begin
      report_mismatch($sformatf("result with none pending: lag %0d value %0d",
                                out_tdata[LAG_W-1:0],
                                $signed(out_tdata[LAG_W+VALUE_W-1:LAG_W])));
    end else begin
      want = lag_queue.pop_front();
      results_seen++;
      if (out_tdata[LAG_W-1:0] !== want.lag)
        report_mismatch($sformatf("lag_index %0d, want %0d",
                                  out_tdata[LAG_W-1:0], want.lag));
      if (out_tdata[LAG_W+VALUE_W-1:LAG_W] !== want.acc_value)
        report_mismatch($sformatf("lag %0d value %0d, want %0d", want.lag,
                                  $signed(out_tdata[LAG_W+VALUE_W-1:LAG_W]),
                                  $signed(want.acc_value)));
      if (out_tlast !== want.last)
        report_mismatch($sformatf("lag %0d tlast %b, want %b", want.lag, out_tlast,
                                  want.last));
      if (out_tuser !== want.cfg_err)
        report_mismatch($sformatf("lag %0d config_error %b, want %b", want.lag,
                                  out_tuser, want.cfg_err));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        accumulate_sample(in_tdata);
        samples_taken++;
        sample_taken_flag = 1'b1;
      end
      if (out_tvalid && out_tready)
        check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: hold the current sample until its transfer, then advance or idle
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || sample_taken_flag) begin
      sample_taken_flag = 1'b0;
      if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= sample_backlog.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random at the current rate
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic queue_sample(input logic [SAMPLE_W-1:0] x);
    sample_backlog.push_back(x);
    samples_queued++;
  endtask

  // Wait for every sample to transfer and every lag sum to arrive, then settle
  task automatic wait_idle();
    do
      @(negedge clk);
    while (samples_taken != samples_queued || lag_queue.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Single-cycle register write; update the shadow copy alongside
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FLEN_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_FRAME_LEN)
      frame_len_reg = data;
    else
      order_reg = data[LAG_W-1:0];
  endtask

  // Full-scale values turn up often; the rest are uniform over 16 bits
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int random_count;
    int len;
    int order;
    int n;
    logic [FLEN_W-1:0] flen;
    logic [FLEN_W-1:0] order_word;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Zero frame length acts as one; order zero returns lag 0 of each sample
    write_reg(REG_FRAME_LEN, 13'd0);
    write_reg(REG_LAG_ORDER, 13'd0);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    wait_idle();

    // Frame no longer than the order: one error result per frame
    write_reg(REG_LAG_ORDER, 13'd1);
    queue_sample(16'h1234);
    wait_idle();

    // Short normal frame with full-scale samples
    write_reg(REG_FRAME_LEN, 13'd3);
    write_reg(REG_LAG_ORDER, 13'd2);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    queue_sample(16'hFFFF);
    wait_idle();

    // Order above the delay line saturates; still longer than this frame
    write_reg(REG_FRAME_LEN, 13'd5);
    write_reg(REG_LAG_ORDER, 13'd63);
    queue_sample(16'h0000);
    queue_sample(16'h0001);
    queue_sample(16'hFFFF);
    queue_sample(16'h7FFF);
    queue_sample(16'h8000);
    wait_idle();

    // Shrink the frame below its fill part-way through: the next sample closes it
    write_reg(REG_FRAME_LEN, 13'd8);
    write_reg(REG_LAG_ORDER, 13'd3);
    repeat (5) queue_sample(pick_sample());
    wait_idle();
    write_reg(REG_FRAME_LEN, 13'd4);
    write_reg(REG_LAG_ORDER, 13'd2);
    queue_sample(pick_sample());
    wait_idle();

    // Frame length above the limit saturates, so a short run of alternating
    // extremes at full order leaves the frame open
    write_reg(REG_FRAME_LEN, 13'h1FFF);
    write_reg(REG_LAG_ORDER, 13'd32);
    for (int i = 0; i < 20; i++)
      queue_sample((i % 2 == 0) ? 16'h8000 : 16'h7FFF);
    wait_idle();

    // Shortest frame that still yields every lag; the open frame closes first
    write_reg(REG_FRAME_LEN, 13'd33);
    repeat (33) queue_sample(pick_sample());
    wait_idle();

    // Random phases: mostly whole frames, some broken off part-way so that the
    // next phase changes the registers mid-frame
    random_count = 0;
    while (random_count < RANDOM_SAMPLES) begin
      if (random_count >= 2 * RANDOM_SAMPLES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_count >= RANDOM_SAMPLES / 3) begin
        send_idle_pct = 45;
        recv_idle_pct = 23;
      end
      wait_idle();

      case ($urandom_range(0, 9))
        0:       flen = '0;
        1:       flen = FLEN_W'($urandom_range(41, 100));
        default: flen = FLEN_W'($urandom_range(1, 40));
      endcase
      len = (flen == '0) ? 1 : int'(flen);
      if ($urandom_range(0, 3) != 0 && len > 1)
        order = $urandom_range(0, (len - 1 < ORDER_MAX_DEF) ? len - 1 : ORDER_MAX_DEF);
      else
        order = $urandom_range(0, 63);
      // Upper write-data bits are ignored for the order; set them now and then
      order_word = FLEN_W'(order);
      if ($urandom_range(0, 4) == 0)
        order_word = order_word | (FLEN_W'($urandom) & 13'h1FC0);

      case ($urandom_range(0, 3))
        0:       write_reg(REG_FRAME_LEN, flen);
        1:       write_reg(REG_LAG_ORDER, order_word);
        default: begin
          write_reg(REG_FRAME_LEN, flen);
          write_reg(REG_LAG_ORDER, order_word);
        end
      endcase

      len = eff_frame_len();
      if ($urandom_range(0, 4) != 0)
        n = ((len > frame_fill) ? len - frame_fill : 1) + len * $urandom_range(0, 1);
      else
        n = $urandom_range(1, len);
      // Keep the run close to its sample budget
      if (n > RANDOM_SAMPLES - random_count)
        n = RANDOM_SAMPLES - random_count;
      repeat (n) queue_sample(pick_sample());
      random_count += n;
    end

    wait_idle();
    $display("Streamed %0d samples through %0d frames (%0d too short for their order).",
             samples_taken, frames_closed, error_frames);
    $display("Checked %0d lag results under three idling patterns on both channels.",
             results_seen);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/fac_pkg.sv
rtl/fac_cell.sv
rtl/fac_ctrl.sv
rtl/frame_autocorrelation.sv
sim/frame_autocorrelation_tb.sv
